@@ rtl/vsr_pkg.sv @@
// Shared types, constants and scroll helpers for the video scroll/timing register unit.
`default_nettype none

package vsr_pkg;

	localparam int OAM_BYTES = 256;
	localparam int OAM_AW    = $clog2(OAM_BYTES);

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	localparam logic [2:0] REG_CTRL   = 3'd0;
	localparam logic [2:0] REG_MASK   = 3'd1;
	localparam logic [2:0] REG_STATUS = 3'd2;
	localparam logic [2:0] REG_OAMADR = 3'd3;
	localparam logic [2:0] REG_OAMDAT = 3'd4;
	localparam logic [2:0] REG_SCROLL = 3'd5;
	localparam logic [2:0] REG_ADDR   = 3'd6;
	localparam logic [2:0] REG_DATA   = 3'd7;

	localparam logic [9:0]        DOTS_PER_LINE = 10'd341;
	localparam logic signed [9:0] LINE_PRE      = -10'sd1;
	localparam logic signed [9:0] LINE_VBLANK   = 10'sd241;
	localparam logic signed [9:0] LINE_WRAP     = 10'sd261;
	localparam logic signed [9:0] LINE_VISIBLE  = 10'sd240;
	localparam logic [8:0]        DOT_VCOPY_LO  = 9'd280;
	localparam logic [8:0]        DOT_VCOPY_HI  = 9'd304;
	localparam logic [8:0]        DOT_FINE_Y    = 9'd256;
	localparam logic [8:0]        DOT_HCOPY     = 9'd257;
	localparam logic [8:0]        DOT_SKIP      = 9'd339;
	localparam logic [8:0]        DOT_LAST      = 9'd340;

	localparam logic [14:0] HORIZ_BITS = 15'h041F;
	localparam logic [14:0] VERT_BITS  = 15'h7BE0;

	typedef struct packed {
		logic [1:0] operation;
		logic [2:0] reg_index;
		logic [7:0] write_data;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0]        read_data;
		logic [14:0]       vram_addr;
		logic [2:0]        fine_x;
		logic              mem_access;
		logic [13:0]       mem_addr;
		logic              mem_write;
		logic              nmi_request;
		logic              frame_done;
		logic signed [9:0] scanline;
		logic [8:0]        dot;
	} res_item_t;

	typedef struct packed {
		logic              we;
		logic [OAM_AW-1:0] waddr;
		logic [7:0]        wdata;
		logic [OAM_AW-1:0] raddr;
	} oam_req_t;

	function automatic logic [14:0] coarse_x_inc(input logic [14:0] v);
		logic [14:0] r;
		r = v;
		if (v[4:0] == 5'd31) begin
			r[4:0] = 5'd0;
			r[10]  = ~v[10];
		end else begin
			r[4:0] = v[4:0] + 5'd1;
		end
		return r;
	endfunction

	function automatic logic [14:0] fine_y_inc(input logic [14:0] v);
		logic [14:0] r;
		logic [4:0]  row;
		r   = v;
		row = v[9:5];
		if (v[14:12] != 3'd7) begin
			r[14:12] = v[14:12] + 3'd1;
		end else begin
			r[14:12] = 3'd0;
			if (row == 5'd29) begin
				row   = 5'd0;
				r[11] = ~v[11];
			end else if (row == 5'd31) begin
				row = 5'd0;
			end else begin
				row = row + 5'd1;
			end
			r[9:5] = row;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/vsr_cmd_if.sv @@
// Command channel: dot ticks and register accesses.
`default_nettype none

interface vsr_cmd_if
	import vsr_pkg::*;
;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [2:0] reg_index;
	logic [7:0] write_data;

	modport source(output valid, operation, reg_index, write_data, input ready);
	modport sink(input valid, operation, reg_index, write_data, output ready);
endinterface

`default_nettype wire

@@ rtl/vsr_res_if.sv @@
// Result channel: read data, scroll address, memory access and timing.
`default_nettype none

interface vsr_res_if
	import vsr_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [7:0]        read_data;
	logic [14:0]       vram_addr;
	logic [2:0]        fine_x;
	logic              mem_access;
	logic [13:0]       mem_addr;
	logic              mem_write;
	logic              nmi_request;
	logic              frame_done;
	logic signed [9:0] scanline;
	logic [8:0]        dot;

	modport source(output valid, read_data, vram_addr, fine_x, mem_access, mem_addr,
		mem_write, nmi_request, frame_done, scanline, dot, input ready);
	modport sink(input valid, read_data, vram_addr, fine_x, mem_access, mem_addr,
		mem_write, nmi_request, frame_done, scanline, dot, output ready);
endinterface

`default_nettype wire

@@ rtl/vsr_oam_ram.sv @@
// Sprite attribute memory with per-entry valid bits; unwritten entries read as 0xFF.
`default_nettype none

module vsr_oam_ram
	import vsr_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire oam_req_t req,
	output logic [7:0]    rdata
);

	logic [7:0]           mem [OAM_BYTES];
	logic [OAM_BYTES-1:0] vld_q;
	logic [7:0]           rd_q;
	logic                 rvld_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_q <= mem[req.raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			rvld_q <= vld_q[req.raddr];
		end
	end

	assign rdata = rvld_q ? rd_q : 8'hFF;

endmodule

`default_nettype wire

@@ rtl/vsr_state.sv @@
// Register file, scroll address and dot/line timing: next-state logic and state registers.
`default_nettype none

module vsr_state
	import vsr_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  wire cmd_item_t cmd,
	input  wire logic [7:0] oam_rdata,
	output oam_req_t       oam_req,
	output res_item_t      res
);

	logic [7:0]        ctrl_q, ctrl_d;
	logic [7:0]        mask_q, mask_d;
	logic              vbl_q, vbl_d;
	logic              tgl_q, tgl_d;
	logic [14:0]       cur_q, cur_d;
	logic [14:0]       tmp_q, tmp_d;
	logic [2:0]        fx_q, fx_d;
	logic [OAM_AW-1:0] ptr_q, ptr_d;
	logic signed [9:0] line_q, line_d;
	logic [8:0]        dot_q, dot_d;
	logic              odd_q, odd_d;

	logic              rendering;
	logic              pre_line;
	logic [9:0]        dot_inc;
	logic [14:0]       step_inc;
	logic [7:0]        d;

	assign d         = cmd.write_data;
	assign rendering = mask_q[3] | mask_q[4];
	assign pre_line  = (line_q == LINE_PRE);
	assign dot_inc   = {1'b0, dot_q} + 10'd1;
	assign step_inc  = ctrl_q[2] ? 15'd32 : 15'd1;

	always_comb begin
		ctrl_d = ctrl_q;
		mask_d = mask_q;
		vbl_d  = vbl_q;
		tgl_d  = tgl_q;
		cur_d  = cur_q;
		tmp_d  = tmp_q;
		fx_d   = fx_q;
		ptr_d  = ptr_q;
		line_d = line_q;
		dot_d  = dot_q;
		odd_d  = odd_q;

		res             = '0;
		oam_req.we      = 1'b0;
		oam_req.waddr   = ptr_q;
		oam_req.wdata   = d;

		case (cmd.operation)
			OP_TICK: begin
				if (pre_line && dot_q == 9'd1) begin
					vbl_d = 1'b0;
				end
				if (rendering) begin
					if (pre_line && dot_q >= DOT_VCOPY_LO && dot_q <= DOT_VCOPY_HI) begin
						cur_d = (cur_q & HORIZ_BITS) | (tmp_q & VERT_BITS);
					end
					if (line_q >= LINE_PRE && line_q < LINE_VISIBLE) begin
						if (dot_q != 9'd0 && dot_q <= DOT_FINE_Y && dot_q[2:0] == 3'd0) begin
							cur_d = coarse_x_inc(cur_d);
						end
						if (dot_q == DOT_FINE_Y) begin
							cur_d = fine_y_inc(cur_d);
						end
						if (dot_q == DOT_HCOPY) begin
							cur_d = (cur_q & VERT_BITS) | (tmp_q & HORIZ_BITS);
						end
					end
				end
				dot_d = dot_inc[8:0];
				if (dot_inc >= DOTS_PER_LINE) begin
					dot_d  = 9'd0;
					line_d = line_q + 10'sd1;
					if (line_d == LINE_VBLANK) begin
						vbl_d          = 1'b1;
						res.frame_done = 1'b1;
						res.nmi_request = ctrl_q[7];
					end else if (line_d >= LINE_WRAP) begin
						line_d = LINE_PRE;
						odd_d  = ~odd_q;
					end
				end
				// odd frames drop one pre-render dot while rendering
				if (line_d == LINE_PRE && dot_d == DOT_SKIP && rendering && odd_d) begin
					dot_d = DOT_LAST;
				end
			end
			OP_READ: begin
				case (cmd.reg_index)
					REG_STATUS: begin
						res.read_data = {vbl_q, 7'd0};
						vbl_d = 1'b0;
						tgl_d = 1'b0;
					end
					REG_OAMDAT: begin
						res.read_data = oam_rdata;
					end
					REG_DATA: begin
						res.mem_access = 1'b1;
						res.mem_addr   = cur_q[13:0];
						cur_d          = cur_q + step_inc;
					end
					default: begin
					end
				endcase
			end
			OP_WRITE: begin
				case (cmd.reg_index)
					REG_CTRL: begin
						ctrl_d        = d;
						tmp_d[11:10]  = d[1:0];
						res.nmi_request = ~ctrl_q[7] & d[7] & vbl_q;
					end
					REG_MASK: begin
						mask_d = d;
					end
					REG_OAMADR: begin
						ptr_d = d[OAM_AW-1:0];
					end
					REG_OAMDAT: begin
						oam_req.we = 1'b1;
						ptr_d      = ptr_q + OAM_AW'(1);
					end
					REG_SCROLL: begin
						if (!tgl_q) begin
							fx_d       = d[2:0];
							tmp_d[4:0] = d[7:3];
							tgl_d      = 1'b1;
						end else begin
							tmp_d[14:12] = d[2:0];
							tmp_d[9:5]   = d[7:3];
							tgl_d        = 1'b0;
						end
					end
					REG_ADDR: begin
						if (!tgl_q) begin
							tmp_d[14]   = 1'b0;
							tmp_d[13:8] = d[5:0];
							tgl_d       = 1'b1;
						end else begin
							tmp_d[7:0] = d;
							cur_d      = {tmp_q[14:8], d};
							tgl_d      = 1'b0;
						end
					end
					REG_DATA: begin
						res.mem_access = 1'b1;
						res.mem_write  = 1'b1;
						res.mem_addr   = cur_q[13:0];
						cur_d          = cur_q + step_inc;
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		res.vram_addr = cur_d;
		res.fine_x    = fx_d;
		res.scanline  = line_d;
		res.dot       = dot_d;

		oam_req.we    = oam_req.we & fire;
		// read port tracks the pointer as it stands after this edge
		oam_req.raddr = fire ? ptr_d : ptr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
			mask_q <= '0;
			vbl_q  <= 1'b0;
			tgl_q  <= 1'b0;
			cur_q  <= '0;
			tmp_q  <= '0;
			fx_q   <= '0;
			ptr_q  <= '0;
			line_q <= LINE_PRE;
			dot_q  <= '0;
			odd_q  <= 1'b0;
		end else if (fire) begin
			ctrl_q <= ctrl_d;
			mask_q <= mask_d;
			vbl_q  <= vbl_d;
			tgl_q  <= tgl_d;
			cur_q  <= cur_d;
			tmp_q  <= tmp_d;
			fx_q   <= fx_d;
			ptr_q  <= ptr_d;
			line_q <= line_d;
			dot_q  <= dot_d;
			odd_q  <= odd_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/video_scroll_timing_registers_unit.sv @@
// Video scroll/timing register unit: input register, state update, result register.
// The result is registered once the state update fires, which waits while a held result is not taken.
// Throughput: one item per cycle while results are taken; the state update is one pass of logic per item.
// Reset (arst_n low): state and valid registers zero, scanline -1, dot 0; sprite memory entries
// read as 0xFF until written, tracked by per-entry valid bits cleared at reset.
`default_nettype none

module video_scroll_timing_registers_unit
	import vsr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	vsr_cmd_if.sink   cmd,
	vsr_res_if.source res
);

	cmd_item_t cmd_s1;
	logic      vld_s1;
	res_item_t res_d;
	res_item_t res_s2;
	logic      vld_s2;
	logic      fire;
	oam_req_t  oam_req;
	logic [7:0] oam_rdata;

	assign fire      = vld_s1 & (~vld_s2 | res.ready);
	assign cmd.ready = ~vld_s1 | fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				vld_s1 <= 1'b1;
			end else if (fire) begin
				vld_s1 <= 1'b0;
			end
			if (fire) begin
				vld_s2 <= 1'b1;
			end else if (res.ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1.operation  <= cmd.operation;
			cmd_s1.reg_index  <= cmd.reg_index;
			cmd_s1.write_data <= cmd.write_data;
		end
		if (fire) begin
			res_s2 <= res_d;
		end
	end

	vsr_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.cmd       (cmd_s1),
		.oam_rdata (oam_rdata),
		.oam_req   (oam_req),
		.res       (res_d)
	);

	vsr_oam_ram u_oam (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (oam_req),
		.rdata  (oam_rdata)
	);

	assign res.valid       = vld_s2;
	assign res.read_data   = res_s2.read_data;
	assign res.vram_addr   = res_s2.vram_addr;
	assign res.fine_x      = res_s2.fine_x;
	assign res.mem_access  = res_s2.mem_access;
	assign res.mem_addr    = res_s2.mem_addr;
	assign res.mem_write   = res_s2.mem_write;
	assign res.nmi_request = res_s2.nmi_request;
	assign res.frame_done  = res_s2.frame_done;
	assign res.scanline    = res_s2.scanline;
	assign res.dot         = res_s2.dot;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for the video scroll/timing register unit: item queue, driver, predictor and monitor.
`default_nettype none

module testbench;
	import vsr_pkg::*;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         PROBE_POS   = 600;   // mid-line on the first visible scanline
	localparam int         STALL_LIMIT = 2000;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	vsr_cmd_if cmd_ch();
	vsr_res_if res_ch();

	logic      cmd_valid = 1'b0;
	cmd_item_t cmd_word  = '0;
	logic      res_ready = 1'b0;

	assign cmd_ch.valid      = cmd_valid;
	assign cmd_ch.operation  = cmd_word.operation;
	assign cmd_ch.reg_index  = cmd_word.reg_index;
	assign cmd_ch.write_data = cmd_word.write_data;
	assign res_ch.ready      = res_ready;

	video_scroll_timing_registers_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	cmd_item_t pending_items[$];
	res_item_t expected_results[$];
	int        sent_count   = 0;
	int        taken_count  = 0;
	int        error_count  = 0;
	int        stall_cycles = 0;
	int        src_gap      = 0;
	int        sink_gap     = 0;
	logic      idling       = 1'b1;

	// predictor state
	logic [7:0]  ctrl_q    = '0;
	logic [7:0]  mask_q    = '0;
	logic        vblank_q  = 1'b0;
	logic        toggle_q  = 1'b0;
	logic [14:0] v_q       = '0;
	logic [14:0] t_q       = '0;
	logic [2:0]  fx_q      = '0;
	logic [7:0]  oam_ptr_q = '0;
	logic [7:0]  oam_copy [OAM_BYTES] = '{default: 8'hFF};
	int          line_q    = -1;
	int          dot_q     = 0;
	logic        odd_q     = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	function automatic logic [14:0] bump_coarse_x(input logic [14:0] a);
		if (a[4:0] != 5'd31)
			return a + 15'd1;
		return {a[14:11], ~a[10], a[9:5], 5'd0};
	endfunction

	function automatic logic [14:0] bump_fine_y(input logic [14:0] a);
		logic [4:0] coarse;
		if (a[14:12] != 3'b111)
			return a + 15'h1000;
		coarse = a[9:5];
		a[14:12] = 3'b000;
		case (coarse)
			5'd29: begin
				coarse = 5'd0;
				a[11] = ~a[11];
			end
			5'd31: coarse = 5'd0;
			default: coarse = coarse + 5'd1;
		endcase
		a[9:5] = coarse;
		return a;
	endfunction

	task automatic advance_model(input cmd_item_t c, output res_item_t r);
		logic       drawing;
		logic [7:0] d;
		d = c.write_data;
		r = '0;
		case (c.operation)
			OP_TICK: begin
				drawing = mask_q[3] | mask_q[4];
				if (line_q == -1 && dot_q == 1)
					vblank_q = 1'b0;
				if (drawing) begin
					if (line_q == -1 && dot_q >= 280 && dot_q <= 304)
						v_q = (v_q & HORIZ_BITS) | (t_q & VERT_BITS);
					if (line_q < 240) begin
						if (dot_q > 0 && dot_q <= 256 && dot_q % 8 == 0)
							v_q = bump_coarse_x(v_q);
						if (dot_q == 256)
							v_q = bump_fine_y(v_q);
						if (dot_q == 257)
							v_q = (v_q & VERT_BITS) | (t_q & HORIZ_BITS);
					end
				end
				dot_q++;
				if (dot_q >= 341) begin
					dot_q = 0;
					line_q++;
					if (line_q == 241) begin
						vblank_q = 1'b1;
						r.frame_done = 1'b1;
						r.nmi_request = ctrl_q[7];
					end else if (line_q >= 261) begin
						line_q = -1;
						odd_q = ~odd_q;
					end
				end
				// odd-frame dot skip uses rendering as sampled before the tick
				if (line_q == -1 && dot_q == 339 && drawing && odd_q)
					dot_q = 340;
			end
			OP_READ: begin
				case (c.reg_index)
					REG_STATUS: begin
						r.read_data = {vblank_q, 7'd0};
						vblank_q = 1'b0;
						toggle_q = 1'b0;
					end
					REG_OAMDAT: r.read_data = oam_copy[oam_ptr_q];
					REG_DATA: begin
						r.mem_access = 1'b1;
						r.mem_addr = v_q[13:0];
						v_q = v_q + (ctrl_q[2] ? 15'd32 : 15'd1);
					end
					default: ;
				endcase
			end
			OP_WRITE: begin
				case (c.reg_index)
					REG_CTRL: begin
						if (!ctrl_q[7] && d[7] && vblank_q)
							r.nmi_request = 1'b1;
						ctrl_q = d;
						t_q[11:10] = d[1:0];
					end
					REG_MASK: mask_q = d;
					REG_OAMADR: oam_ptr_q = d;
					REG_OAMDAT: begin
						oam_copy[oam_ptr_q] = d;
						oam_ptr_q = oam_ptr_q + 8'd1;
					end
					REG_SCROLL: begin
						if (!toggle_q) begin
							fx_q = d[2:0];
							t_q[4:0] = d[7:3];
						end else begin
							t_q = {d[2:0], t_q[11:10], d[7:3], t_q[4:0]};
						end
						toggle_q = ~toggle_q;
					end
					REG_ADDR: begin
						if (!toggle_q) begin
							t_q = {1'b0, d[5:0], t_q[7:0]};
						end else begin
							t_q = {t_q[14:8], d};
							v_q = t_q;
						end
						toggle_q = ~toggle_q;
					end
					REG_DATA: begin
						r.mem_access = 1'b1;
						r.mem_write = 1'b1;
						r.mem_addr = v_q[13:0];
						v_q = v_q + (ctrl_q[2] ? 15'd32 : 15'd1);
					end
					default: ;
				endcase
			end
			default: ;
		endcase
		r.vram_addr = v_q;
		r.fine_x = fx_q;
		r.scanline = line_q[9:0];
		r.dot = dot_q[8:0];
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h, got %h", $time, name, want, got);
			error_count++;
		end
	endtask

	// driver: inputs change on the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (sent_count == taken_count) begin
				if (src_gap > 0) begin
					src_gap--;
					cmd_valid <= 1'b0;
				end else if (idling && $urandom_range(0, 63) == 0) begin
					src_gap = $urandom_range(0, 17);
					cmd_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					cmd_word <= pending_items.pop_front();
					cmd_valid <= 1'b1;
					sent_count++;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				res_ready <= 1'b0;
			end else if (idling && $urandom_range(0, 63) == 0) begin
				sink_gap = $urandom_range(0, 17);
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// monitor: both channels sampled on the rising edge
	always @(posedge clk) begin : monitor
		res_item_t predicted;
		res_item_t want;
		logic      moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cmd_valid && cmd_ch.ready) begin
				advance_model(cmd_word, predicted);
				expected_results.push_back(predicted);
				taken_count++;
				moved = 1'b1;
			end
			if (res_ch.valid && res_ready) begin
				moved = 1'b1;
				if (expected_results.size() == 0) begin
					$display("%0t: no result expected, got vram_addr %h dot %h", $time,
						res_ch.vram_addr, res_ch.dot);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("read_data", 16'(want.read_data), 16'(res_ch.read_data));
					check_field("vram_addr", 16'(want.vram_addr), 16'(res_ch.vram_addr));
					check_field("fine_x", 16'(want.fine_x), 16'(res_ch.fine_x));
					check_field("mem_access", 16'(want.mem_access),
						16'(res_ch.mem_access));
					check_field("mem_addr", 16'(want.mem_addr), 16'(res_ch.mem_addr));
					check_field("mem_write", 16'(want.mem_write), 16'(res_ch.mem_write));
					check_field("nmi_request", 16'(want.nmi_request),
						16'(res_ch.nmi_request));
					check_field("frame_done", 16'(want.frame_done),
						16'(res_ch.frame_done));
					check_field("scanline", 16'(want.scanline), 16'(res_ch.scanline));
					check_field("dot", 16'(want.dot), 16'(res_ch.dot));
				end
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
		end
	end

	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("[video_scroll_timing_registers_unit] ERROR");
		$finish;
	end

	task automatic queue_item(input logic [1:0] op, input logic [2:0] idx, input logic [7:0] data);
		pending_items.push_back('{operation: op, reg_index: idx, write_data: data});
	endtask

	function automatic cmd_item_t random_access();
		cmd_item_t c;
		if ($urandom_range(0, 15) == 0)
			c.operation = OP_UNUSED;
		else
			c.operation = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
		c.reg_index = 3'($urandom_range(0, 7));
		c.write_data = 8'($urandom_range(0, 255));
		return c;
	endfunction

	task automatic wait_idle();
		while (pending_items.size() != 0 || sent_count != taken_count ||
			expected_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int pos;
		int left;
		int n;
		// directed: register corners, starting at pre-render dot 0
		queue_item(OP_READ, REG_STATUS, 8'h00);
		queue_item(OP_READ, REG_OAMDAT, 8'hFF);
		queue_item(OP_READ, REG_CTRL, 8'hFF);
		queue_item(OP_WRITE, REG_STATUS, 8'hFF);
		queue_item(OP_UNUSED, REG_DATA, 8'hFF);
		queue_item(OP_WRITE, REG_OAMADR, 8'hFF);
		queue_item(OP_WRITE, REG_OAMDAT, 8'h00);      // pointer wraps to 0
		queue_item(OP_READ, REG_OAMDAT, 8'h00);
		queue_item(OP_WRITE, REG_OAMADR, 8'hFF);
		queue_item(OP_READ, REG_OAMDAT, 8'h00);
		queue_item(OP_WRITE, REG_CTRL, 8'h03);
		queue_item(OP_WRITE, REG_SCROLL, 8'hFF);
		queue_item(OP_WRITE, REG_SCROLL, 8'hFF);      // temp address all ones
		queue_item(OP_WRITE, REG_MASK, 8'h18);
		// ticks through the X copy and the whole Y copy window: address goes to 0x7FFF
		for (int i = 0; i < 305; i++)
			queue_item(OP_TICK, REG_CTRL, 8'h00);
		queue_item(OP_WRITE, REG_DATA, 8'hA5);        // address wraps to 0
		queue_item(OP_READ, REG_DATA, 8'h00);
		queue_item(OP_WRITE, REG_CTRL, 8'h84);        // step of 32
		queue_item(OP_READ, REG_DATA, 8'h00);
		queue_item(OP_WRITE, REG_ADDR, 8'hFF);
		queue_item(OP_WRITE, REG_ADDR, 8'h00);
		queue_item(OP_WRITE, REG_SCROLL, 8'h5A);
		queue_item(OP_READ, REG_STATUS, 8'h00);       // clears the write toggle
		queue_item(OP_WRITE, REG_SCROLL, 8'hA5);
		queue_item(OP_WRITE, REG_CTRL, 8'h00);
		wait_idle();

		// ticks with clusters of random accesses
		pos = 305;
		left = 500;
		while (left > 0) begin
			if (pos == PROBE_POS) begin
				// interrupt enable edges, then status read and another enabling write
				queue_item(OP_WRITE, REG_CTRL, {1'b0, 7'($urandom_range(0, 127))});
				queue_item(OP_WRITE, REG_CTRL, {1'b1, 7'($urandom_range(0, 127))});
				queue_item(OP_READ, REG_STATUS, 8'h00);
				queue_item(OP_WRITE, REG_CTRL, {1'b1, 7'($urandom_range(0, 127))});
			end
			if ($urandom_range(0, 15) == 0) begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					pending_items.push_back(random_access());
			end
			queue_item(OP_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
			pos++;
			left--;
		end
		wait_idle();

		// dense mix at full rate
		idling = 1'b0;
		for (int i = 0; i < 300; i++) begin
			if ($urandom_range(0, 1))
				queue_item(OP_TICK, REG_CTRL, 8'h00);
			else
				pending_items.push_back(random_access());
		end
		wait_idle();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("[video_scroll_timing_registers_unit] OK");
		else
			$display("[video_scroll_timing_registers_unit] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
